@@ sv/bsdot_pkg.sv @@
// Shared types, constants and fp32 arithmetic functions for the block-scaled
// FP4 x INT8 dot product. No dependencies.
package bsdot_pkg;

	// Largest magnitude of one act * weight product (128 * 12)
	localparam int PROD_MAX = 1536;
	localparam int PROD_W = 13;
	// Sum widths in the job record, sized for the largest supported group
	localparam int SUM_W = 19;
	localparam int JOB_DEPTH = 2;

	localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;

	// Doubled E2M1 magnitudes
	localparam logic [3:0] FP4_MAG2 [8] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd8, 4'd12};

	typedef enum logic [2:0] {
		B_IDLE,
		B_CVT,
		B_T1,
		B_T3,
		B_T4,
		B_ACC,
		B_RES
	} back_state_t;

	// Work handed from the front to the back
	typedef struct packed {
		logic                    do_pair;
		logic                    do_last;
		logic                    misaligned;
		logic [15:0]             bg0;
		logic [15:0]             bg1;
		logic signed [SUM_W-1:0] pair_sum;
		logic signed [SUM_W-1:0] half_sum;
		logic [31:0]             row_scale;
	} job_t;

	// Round mag * 2^e to fp32, nearest-even, with subnormals
	function automatic logic [31:0] fp_round(input logic sgn, input logic [47:0] mag,
		input int e);
		int p;
		int sh;
		int be;
		logic [48:0] m;
		logic g;
		logic st;
		if (mag == '0) return {sgn, 31'd0};
		p = 0;
		for (int i = 0; i < 48; i++) begin
			if (mag[i]) p = i;
		end
		sh = p - 23;
		if (sh < -149 - e) sh = -149 - e;
		g = 1'b0;
		st = 1'b0;
		if (sh <= 0) begin
			m = {1'b0, mag} << (-sh);
		end else if (sh >= 49) begin
			m = '0;
		end else begin
			m = {1'b0, mag} >> sh;
			g = mag[sh-1];
			st = |(mag & ((48'd1 << (sh - 1)) - 48'd1));
			if (g && (st || m[0])) m = m + 49'd1;
		end
		if (m[24]) begin
			m = m >> 1;
			sh = sh + 1;
		end
		if (m[23]) begin
			be = sh + e + 150;
			if (be >= 255) return {sgn, 8'hFF, 23'd0};
			return {sgn, be[7:0], m[22:0]};
		end
		return {sgn, 8'd0, m[22:0]};
	endfunction

	function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
		logic s;
		logic na;
		logic nb;
		logic ia;
		logic ib;
		logic za;
		logic zb;
		logic [23:0] ma;
		logic [23:0] mb;
		int xa;
		int xb;
		s = a[31] ^ b[31];
		ia = a[30:23] == 8'hFF;
		ib = b[30:23] == 8'hFF;
		na = ia && (a[22:0] != '0);
		nb = ib && (b[22:0] != '0);
		za = a[30:0] == '0;
		zb = b[30:0] == '0;
		if (na || nb || (ia && zb) || (ib && za)) return FP_QNAN;
		if (ia || ib) return {s, 8'hFF, 23'd0};
		if (za || zb) return {s, 31'd0};
		ma = {a[30:23] != 8'd0, a[22:0]};
		mb = {b[30:23] != 8'd0, b[22:0]};
		xa = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
		xb = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
		return fp_round(s, ma * mb, xa + xb - 300);
	endfunction

	function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
		logic ia;
		logic ib;
		logic na;
		logic nb;
		logic [31:0] big;
		logic [31:0] sml;
		logic [23:0] mx;
		logic [23:0] my;
		logic [26:0] ax;
		logic [26:0] ay;
		logic [26:0] yf;
		logic [27:0] sum;
		logic sgn;
		int xx;
		int xy;
		int d;
		ia = a[30:23] == 8'hFF;
		ib = b[30:23] == 8'hFF;
		na = ia && (a[22:0] != '0);
		nb = ib && (b[22:0] != '0);
		if (na || nb || (ia && ib && (a[31] != b[31]))) return FP_QNAN;
		if (ia) return a;
		if (ib) return b;
		if ((a[30:0] == '0) && (b[30:0] == '0)) return {a[31] & b[31], 31'd0};
		if (a[30:23] >= b[30:23]) begin
			big = a;
			sml = b;
		end else begin
			big = b;
			sml = a;
		end
		mx = {big[30:23] != 8'd0, big[22:0]};
		my = {sml[30:23] != 8'd0, sml[22:0]};
		xx = (big[30:23] == 8'd0) ? 1 : int'(big[30:23]);
		xy = (sml[30:23] == 8'd0) ? 1 : int'(sml[30:23]);
		d = xx - xy;
		ax = {mx, 3'b000};
		yf = {my, 3'b000};
		if (d >= 27) begin
			ay = {26'd0, |my};
		end else begin
			ay = (yf >> d) | {26'd0, |(yf & ((27'd1 << d) - 27'd1))};
		end
		// Align with guard, round and sticky bits, then add or subtract
		if (big[31] == sml[31]) begin
			sum = {1'b0, ax} + {1'b0, ay};
			sgn = big[31];
		end else if (ax >= ay) begin
			sum = {1'b0, ax} - {1'b0, ay};
			sgn = big[31];
		end else begin
			sum = {1'b0, ay} - {1'b0, ax};
			sgn = sml[31];
		end
		if (sum == '0) return 32'd0;
		return fp_round(sgn, {20'd0, sum}, xx - 153);
	endfunction

	function automatic logic [31:0] int_to_fp(input logic signed [SUM_W-1:0] v);
		logic [SUM_W-1:0] mag;
		mag = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
		if (v == '0) return 32'd0;
		return fp_round(v[SUM_W-1], 48'(mag), 0);
	endfunction

endpackage

@@ sv/bsdot_ifs.sv @@
// Handshake channel interfaces for the block-scaled dot product.
// Depends on bsdot_pkg for the job record.
interface bsdot_in_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] act;
	logic [3:0]        weight_code;
	logic [15:0]       block_scale;
	logic [31:0]       row_scale;
	logic              last;

	modport source(output valid, act, weight_code, block_scale, row_scale, last, input ready);
	modport sink(input valid, act, weight_code, block_scale, row_scale, last, output ready);
endinterface

interface bsdot_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] dot_value;
	logic        misaligned;

	modport source(output valid, dot_value, misaligned, input ready);
	modport sink(input valid, dot_value, misaligned, output ready);
endinterface

interface bsdot_job_if;
	logic              valid;
	logic              ready;
	bsdot_pkg::job_t   job;

	modport source(output valid, job, input ready);
	modport sink(input valid, job, output ready);
endinterface

@@ sv/bsdot_front.sv @@
// Front end: decodes weights, sums integer products over a block pair and
// hands completed pairs and row ends to the job queue. Uses bsdot_pkg, bsdot_ifs.
module bsdot_front #(
	parameter int GROUP_SIZE = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	bsdot_in_if.sink      item,
	bsdot_job_if.source   jobs
);

	localparam int POS_W = $clog2(2 * GROUP_SIZE);
	localparam int PS_W = $clog2(2 * GROUP_SIZE * bsdot_pkg::PROD_MAX) + 1;
	localparam int HS_W = $clog2(GROUP_SIZE * bsdot_pkg::PROD_MAX) + 1;

	logic [POS_W-1:0]       pos_q;
	logic signed [PS_W-1:0] psum_q;
	logic signed [HS_W-1:0] hsum_q;
	logic [15:0]            bg0_q;
	logic [15:0]            bg1_q;

	logic                              accept;
	logic                              pair_done;
	logic                              first_half;
	logic signed [4:0]                 w;
	logic signed [bsdot_pkg::PROD_W-1:0] prod;
	logic signed [PS_W-1:0]            psum_n;
	logic signed [HS_W-1:0]            hsum_n;

	// Decode the weight and form the product
	always_comb begin
		w = item.weight_code[3] ? -$signed({1'b0, bsdot_pkg::FP4_MAG2[item.weight_code[2:0]]})
			: $signed({1'b0, bsdot_pkg::FP4_MAG2[item.weight_code[2:0]]});
		prod = bsdot_pkg::PROD_W'(item.act * w);
		first_half = pos_q < POS_W'(GROUP_SIZE);
		pair_done = pos_q == POS_W'(2 * GROUP_SIZE - 1);
		psum_n = psum_q + PS_W'(prod);
		hsum_n = first_half ? hsum_q + HS_W'(prod) : hsum_q;
	end

	assign item.ready = jobs.ready;
	assign accept = item.valid && item.ready;

	// Hand a job over at a pair end or a row end
	always_comb begin
		jobs.valid = accept && (pair_done || item.last);
		jobs.job.do_pair = pair_done;
		jobs.job.do_last = item.last;
		jobs.job.misaligned = !pair_done;
		jobs.job.bg0 = bg0_q;
		jobs.job.bg1 = bg1_q;
		jobs.job.pair_sum = bsdot_pkg::SUM_W'(psum_n);
		jobs.job.half_sum = bsdot_pkg::SUM_W'(hsum_n);
		jobs.job.row_scale = item.row_scale;
	end

	// Advance the pair position and running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			psum_q <= '0;
			hsum_q <= '0;
			bg0_q <= '0;
			bg1_q <= '0;
		end else if (accept) begin
			if (item.last || pair_done) begin
				pos_q <= '0;
				psum_q <= '0;
				hsum_q <= '0;
				if (item.last) begin
					bg0_q <= '0;
					bg1_q <= '0;
				end
			end else begin
				pos_q <= pos_q + POS_W'(1);
				psum_q <= psum_n;
				hsum_q <= hsum_n;
				if (pos_q == '0) bg0_q <= item.block_scale;
				if (pos_q == POS_W'(GROUP_SIZE)) bg1_q <= item.block_scale;
			end
		end
	end

endmodule

@@ sv/bsdot_fifo.sv @@
// Short job queue between the front and the back end.
// Uses bsdot_pkg and bsdot_job_if.
module bsdot_fifo (
	input  logic        clk,
	input  logic        arst_n,
	bsdot_job_if.sink   wr,
	bsdot_job_if.source rd
);

	localparam int PTR_W = $clog2(bsdot_pkg::JOB_DEPTH);
	localparam int CNT_W = $clog2(bsdot_pkg::JOB_DEPTH + 1);

	bsdot_pkg::job_t  mem_q [bsdot_pkg::JOB_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign wr.ready = cnt_q != CNT_W'(bsdot_pkg::JOB_DEPTH);
	assign rd.valid = cnt_q != '0;
	assign rd.job = mem_q[rptr_q];
	assign push = wr.valid && wr.ready;
	assign pop = rd.valid && rd.ready;

	// Store the incoming job
	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wr.job;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wptr_q <= (wptr_q == PTR_W'(bsdot_pkg::JOB_DEPTH - 1)) ? '0
				: wptr_q + PTR_W'(1);
			if (pop) rptr_q <= (rptr_q == PTR_W'(bsdot_pkg::JOB_DEPTH - 1)) ? '0
				: rptr_q + PTR_W'(1);
			if (push && !pop) cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule

@@ sv/bsdot_back.sv @@
// Back end: runs the fp32 pair update and the row result one step at a time,
// and holds the result in an output register. Uses bsdot_pkg, bsdot_ifs.
module bsdot_back (
	input  logic         clk,
	input  logic         arst_n,
	bsdot_job_if.sink    jobs,
	bsdot_out_if.source  result
);

	bsdot_pkg::back_state_t state_q;
	bsdot_pkg::back_state_t state_n;

	bsdot_pkg::job_t job_q;
	logic [31:0]     acc_q;
	logic [31:0]     psf_q;
	logic [31:0]     hsf_q;
	logic [31:0]     t2_q;
	logic [31:0]     t1_q;
	logic [31:0]     t3_q;
	logic [31:0]     t4_q;
	logic            out_valid_q;
	logic [31:0]     dot_q;
	logic            mis_q;

	logic out_free;
	logic take_job;
	logic load_out;

	assign out_free = !out_valid_q || result.ready;
	assign result.valid = out_valid_q;
	assign result.dot_value = dot_q;
	assign result.misaligned = mis_q;

	// Next state and step control
	always_comb begin
		state_n = state_q;
		take_job = 1'b0;
		load_out = 1'b0;
		case (state_q)
			bsdot_pkg::B_IDLE: begin
				if (jobs.valid) begin
					take_job = 1'b1;
					state_n = jobs.job.do_pair ? bsdot_pkg::B_CVT : bsdot_pkg::B_RES;
				end
			end
			bsdot_pkg::B_CVT: state_n = bsdot_pkg::B_T1;
			bsdot_pkg::B_T1:  state_n = bsdot_pkg::B_T3;
			bsdot_pkg::B_T3:  state_n = bsdot_pkg::B_T4;
			bsdot_pkg::B_T4:  state_n = bsdot_pkg::B_ACC;
			bsdot_pkg::B_ACC: state_n = job_q.do_last ? bsdot_pkg::B_RES : bsdot_pkg::B_IDLE;
			bsdot_pkg::B_RES: begin
				if (out_free) begin
					load_out = 1'b1;
					state_n = bsdot_pkg::B_IDLE;
				end
			end
			default: state_n = bsdot_pkg::B_IDLE;
		endcase
	end

	assign jobs.ready = take_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= bsdot_pkg::B_IDLE;
		else state_q <= state_n;
	end

	// Latch the job and run the fp32 operations of each step
	always_ff @(posedge clk) begin
		if (take_job) job_q <= jobs.job;
		case (state_q)
			bsdot_pkg::B_CVT: begin
				psf_q <= bsdot_pkg::int_to_fp(job_q.pair_sum);
				hsf_q <= bsdot_pkg::int_to_fp(job_q.half_sum);
				t2_q <= bsdot_pkg::fp_add({job_q.bg0, 16'd0}, {~job_q.bg1[15], job_q.bg1[14:0], 16'd0});
			end
			bsdot_pkg::B_T1: t1_q <= bsdot_pkg::fp_mul({job_q.bg1, 16'd0}, psf_q);
			bsdot_pkg::B_T3: t3_q <= bsdot_pkg::fp_mul(t2_q, hsf_q);
			bsdot_pkg::B_T4: t4_q <= bsdot_pkg::fp_add(t1_q, t3_q);
			default: ;
		endcase
		if (load_out) begin
			dot_q <= bsdot_pkg::fp_mul(job_q.row_scale, acc_q);
			mis_q <= job_q.misaligned;
		end
	end

	// Accumulator: add the pair term, clear once the row result is taken over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == bsdot_pkg::B_ACC) acc_q <= bsdot_pkg::fp_add(acc_q, t4_q);
			else if (load_out) acc_q <= '0;
			if (load_out) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
		end
	end

endmodule

@@ sv/block_scaled_fp4_int8_dot.sv @@
// Top level of the block-scaled FP4 x INT8 dot product.
// Uses bsdot_pkg, bsdot_ifs, bsdot_front, bsdot_fifo and bsdot_back.
//
// Channels: item carries one int8 activation, one E2M1 weight code, the bf16
// scale of its block, the fp32 row scale and a last flag per transaction;
// result carries the fp32 row value and a misaligned flag, one transaction per
// row, sent on the item marked last.
// Throughput: the front takes one item per cycle while the two-entry job queue
// has room. A pair end or a row end queues a job; the back end runs a pair
// update through CVT, T1, T3, T4 and ACC, and a row result in RES, so at the
// default group size a row of full pairs runs at one item per cycle and only
// very short rows are held back by the queue. result.valid rises once the job
// of the last item has left the queue and the back end has run RES, after CVT
// to ACC when that item closes a pair, and later still if jobs are queued ahead.
// Reset clears the sums, scales, accumulator and queue and the output valid flag.
// When the receiver stalls, the result stays registered; the back end then
// holds at its next row result, the queue fills and item.ready falls.
module block_scaled_fp4_int8_dot #(
	parameter int GROUP_SIZE = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	bsdot_in_if.sink    item,
	bsdot_out_if.source result
);

	bsdot_job_if front_jobs ();
	bsdot_job_if back_jobs ();

	bsdot_front #(
		.GROUP_SIZE(GROUP_SIZE)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.jobs(front_jobs.source)
	);

	bsdot_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr(front_jobs.sink),
		.rd(back_jobs.source)
	);

	bsdot_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.jobs(back_jobs.sink),
		.result(result)
	);

endmodule

@@ sv/bsdot_checker.sv @@
// Port-level checks for the block-scaled dot product, bound to the top level.
// Depends on bsdot_pkg for the canonical NaN.
module bsdot_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] dot_value,
	input logic        misaligned
);

	// Hold a stalled result transaction
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(dot_value) && $stable(misaligned))
		else $error("result payload changed while stalled");

	// Any NaN result is the canonical quiet NaN
	a_nan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (dot_value[30:23] == 8'hFF) && (dot_value[22:0] != 23'd0)
		|-> dot_value == bsdot_pkg::FP_QNAN)
		else $error("non-canonical NaN result");

	// No result while in reset
	a_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind block_scaled_fp4_int8_dot bsdot_checker u_bsdot_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.dot_value(result.dot_value),
	.misaligned(result.misaligned)
);
